/* src/fmr_pkg.sv */
// Shared types and constants of the frequency and rate-of-change meter.
package fmr_pkg;

  // Fixed field widths of the item and result channels.
  localparam int RATE_W      = 16;
  localparam int IN_COUNT_W  = 16;
  localparam int STAMP_W     = 32;
  localparam int FREQ_W      = 32;
  localparam int ROCOF_W     = 45;
  localparam int ROCOF_MAG_W = 44;

  // Width of the product of a frequency difference and the sample rate.
  localparam int PROD_W = FREQ_W + RATE_W;

  // Reset value of the sample rate register.
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd16000;

  // Configuration port layout.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREQ_DIV,
    ST_ROC_MUL,
    ST_ROC_START,
    ST_ROC_DIV,
    ST_DONE
  } fmr_state_t;

endpackage

/* src/frequency_and_rocof_meter_core.sv */
// Top level of the frequency and rate-of-change-of-frequency meter.
//
//  Channel  Direction  Handshake                 Payload
//  in_      input      in_valid / in_ready       sample_count, time_stamp
//  out_     output     out_valid / out_ready     frequency, rocof, rocof_valid, count, stamp
//  cfg_     config     APB-style, pready high    sample_rate at byte address 0
//
// A nonzero count makes two passes through the one-bit-per-cycle divider from
// acceptance to result; the first count after reset needs one pass. A zero count is
// taken and dropped. in_ready is high only while the sequencer is idle. rst_n
// is synchronous and clears the stored history. A finished result waits in the
// output register, and the block still takes the next item while it waits.
module frequency_and_rocof_meter_core #(
  parameter int COUNT_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Item channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fmr_pkg::IN_COUNT_W-1:0]      in_sample_count,
  input  logic [fmr_pkg::STAMP_W-1:0]         in_time_stamp,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fmr_pkg::FREQ_W-1:0]          out_frequency_q16,
  output logic signed [fmr_pkg::ROCOF_W-1:0]  out_rocof_q16,
  output logic                                out_rocof_valid,
  output logic [fmr_pkg::IN_COUNT_W-1:0]      out_count_out,
  output logic [fmr_pkg::STAMP_W-1:0]         out_stamp_out,
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fmr_pkg::APB_ADDR_W-1:0]      cfg_paddr,
  input  logic [fmr_pkg::APB_DATA_W-1:0]      cfg_pwdata,
  output logic [fmr_pkg::APB_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  // Only the low bits of the count take part, at most the field width.
  localparam int CW     = (COUNT_BITS < fmr_pkg::IN_COUNT_W) ? COUNT_BITS
                                                             : fmr_pkg::IN_COUNT_W;
  localparam int SUM_W  = CW + 1;
  localparam int FNUM_W = fmr_pkg::RATE_W + FRAC_BITS;
  localparam int RNUM_W = fmr_pkg::PROD_W + 1;
  localparam int NUM_W  = (FNUM_W > RNUM_W) ? FNUM_W : RNUM_W;

  fmr_pkg::fmr_state_t state_r, state_nxt;

  logic [fmr_pkg::RATE_W-1:0]  sample_rate;
  logic [CW-1:0]               count_in;
  logic                        accept;

  // Stored history.
  logic [fmr_pkg::FREQ_W-1:0]  last_freq_r, last_freq_nxt;
  logic [CW-1:0]               last_count_r, last_count_nxt;
  logic                        have_last_r, have_last_nxt;

  // Work registers of the item in flight.
  logic [CW-1:0]               count_r, count_nxt;
  logic [fmr_pkg::STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [fmr_pkg::FREQ_W-1:0]  freq_r, freq_nxt;
  logic [fmr_pkg::FREQ_W-1:0]  diff_r, diff_nxt;
  logic                        neg_r, neg_nxt;
  logic [fmr_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [fmr_pkg::ROCOF_W-1:0] rocof_r, rocof_nxt;
  logic                        rvalid_r, rvalid_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic [fmr_pkg::FREQ_W-1:0]  out_freq_r, out_freq_nxt;
  logic [fmr_pkg::ROCOF_W-1:0] out_rocof_r, out_rocof_nxt;
  logic                        out_rvalid_r, out_rvalid_nxt;
  logic [CW-1:0]               out_count_r, out_count_nxt;
  logic [fmr_pkg::STAMP_W-1:0] out_stamp_r, out_stamp_nxt;

  // Divider interface.
  logic                        div_start;
  logic [NUM_W-1:0]            div_num;
  logic [SUM_W-1:0]            div_den;
  logic                        div_done;
  logic [NUM_W-1:0]            div_quot;

  // Saturated division results.
  logic [fmr_pkg::FREQ_W-1:0]      freq_sat;
  logic [fmr_pkg::ROCOF_MAG_W-1:0] mag_sat;
  logic [fmr_pkg::ROCOF_W-1:0]     mag_ext;

  fmr_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .sample_rate_o (sample_rate)
  );

  fmr_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign count_in = in_sample_count[CW-1:0];
  assign in_ready = (state_r == fmr_pkg::ST_IDLE);
  assign accept   = in_valid & in_ready;

  // Clamp the quotients to their field ranges.
  assign freq_sat = (|div_quot[NUM_W-1:fmr_pkg::FREQ_W]) ? '1
                                                         : div_quot[fmr_pkg::FREQ_W-1:0];
  assign mag_sat  = (|div_quot[NUM_W-1:fmr_pkg::ROCOF_MAG_W]) ? '1
                                                              : div_quot[fmr_pkg::ROCOF_MAG_W-1:0];
  assign mag_ext  = {1'b0, mag_sat};

  // Sequencer: frequency division, multiply, rate division, result hand-off.
  always_comb begin
    state_nxt      = state_r;
    last_freq_nxt  = last_freq_r;
    last_count_nxt = last_count_r;
    have_last_nxt  = have_last_r;
    count_nxt      = count_r;
    stamp_nxt      = stamp_r;
    freq_nxt       = freq_r;
    diff_nxt       = diff_r;
    neg_nxt        = neg_r;
    prod_nxt       = prod_r;
    rocof_nxt      = rocof_r;
    rvalid_nxt     = rvalid_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_freq_nxt   = out_freq_r;
    out_rocof_nxt  = out_rocof_r;
    out_rvalid_nxt = out_rvalid_r;
    out_count_nxt  = out_count_r;
    out_stamp_nxt  = out_stamp_r;
    div_start      = 1'b0;
    div_num        = NUM_W'({sample_rate, {FRAC_BITS{1'b0}}});
    div_den        = SUM_W'(count_in);

    case (state_r)
      fmr_pkg::ST_IDLE: begin
        // A zero count is taken and dropped.
        if (accept && (count_in != '0)) begin
          count_nxt = count_in;
          stamp_nxt = in_time_stamp;
          div_start = 1'b1;
          state_nxt = fmr_pkg::ST_FREQ_DIV;
        end
      end
      fmr_pkg::ST_FREQ_DIV: begin
        if (div_done) begin
          freq_nxt = freq_sat;
          neg_nxt  = (freq_sat < last_freq_r);
          diff_nxt = (freq_sat < last_freq_r) ? (last_freq_r - freq_sat)
                                              : (freq_sat - last_freq_r);
          if (have_last_r) begin
            state_nxt = fmr_pkg::ST_ROC_MUL;
          end else begin
            rocof_nxt  = '0;
            rvalid_nxt = 1'b0;
            state_nxt  = fmr_pkg::ST_DONE;
          end
        end
      end
      fmr_pkg::ST_ROC_MUL: begin
        prod_nxt  = fmr_pkg::PROD_W'(diff_r) * fmr_pkg::PROD_W'(sample_rate);
        state_nxt = fmr_pkg::ST_ROC_START;
      end
      fmr_pkg::ST_ROC_START: begin
        // Divide twice the product by the sum of both counts.
        div_start = 1'b1;
        div_num   = NUM_W'({prod_r, 1'b0});
        div_den   = SUM_W'(count_r) + SUM_W'(last_count_r);
        state_nxt = fmr_pkg::ST_ROC_DIV;
      end
      fmr_pkg::ST_ROC_DIV: begin
        if (div_done) begin
          rocof_nxt  = neg_r ? (~mag_ext + 1'b1) : mag_ext;
          rvalid_nxt = 1'b1;
          state_nxt  = fmr_pkg::ST_DONE;
        end
      end
      fmr_pkg::ST_DONE: begin
        // Load the output register once it is free, and update the history.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_freq_nxt   = freq_r;
          out_rocof_nxt  = rocof_r;
          out_rvalid_nxt = rvalid_r;
          out_count_nxt  = count_r;
          out_stamp_nxt  = stamp_r;
          last_freq_nxt  = freq_r;
          last_count_nxt = count_r;
          have_last_nxt  = 1'b1;
          state_nxt      = fmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fmr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state and stored history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fmr_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      last_freq_r  <= '0;
      last_count_r <= '0;
      have_last_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      last_freq_r  <= last_freq_nxt;
      last_count_r <= last_count_nxt;
      have_last_r  <= have_last_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    count_r      <= count_nxt;
    stamp_r      <= stamp_nxt;
    freq_r       <= freq_nxt;
    diff_r       <= diff_nxt;
    neg_r        <= neg_nxt;
    prod_r       <= prod_nxt;
    rocof_r      <= rocof_nxt;
    rvalid_r     <= rvalid_nxt;
    out_freq_r   <= out_freq_nxt;
    out_rocof_r  <= out_rocof_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_count_r  <= out_count_nxt;
    out_stamp_r  <= out_stamp_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_frequency_q16 = out_freq_r;
  assign out_rocof_q16     = out_rocof_r;
  assign out_rocof_valid   = out_rvalid_r;
  assign out_count_out     = fmr_pkg::IN_COUNT_W'(out_count_r);
  assign out_stamp_out     = out_stamp_r;

endmodule

/* src/fmr_cfg.sv */
// Configuration register file with an APB-style access port.
module fmr_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fmr_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [fmr_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [fmr_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output logic [fmr_pkg::RATE_W-1:0]      sample_rate_o
);

  logic [fmr_pkg::RATE_W-1:0]    sample_rate_r;
  logic [fmr_pkg::RATE_W-1:0]    sample_rate_nxt;
  logic [fmr_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  // The port never inserts wait states.
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[fmr_pkg::APB_ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register write decode; writes to unknown registers are ignored.
  always_comb begin
    sample_rate_nxt = sample_rate_r;
    if (wr_en && (reg_idx == fmr_pkg::REG_SAMPLE_RATE)) begin
      sample_rate_nxt = cfg_pwdata[fmr_pkg::RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= fmr_pkg::RATE_RESET;
    end else begin
      sample_rate_r <= sample_rate_nxt;
    end
  end

  // Read back.
  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == fmr_pkg::REG_SAMPLE_RATE) begin
      cfg_prdata = fmr_pkg::APB_DATA_W'(sample_rate_r);
    end
  end

  assign sample_rate_o = sample_rate_r;

endmodule

/* src/fmr_div.sv */
// Shared restoring divider that produces one quotient bit per cycle.
module fmr_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign fits    = (shifted >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      den_nxt  = den_i;
      quo_nxt  = num_i;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done_o = done_r;
  assign quot_o = quo_r;

endmodule
